/* hw/rtl/utf8_to_code_point_decoder_top_assert.svh */
// assertion macros for the utf8 decoder
// uses clk and rst_n of the module that includes it
`ifndef UTF8_TO_CODE_POINT_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_CODE_POINT_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/utf8d_pkg.sv */
// shared types and constants of the utf8 decoder
// no dependencies
package utf8d_pkg;

  localparam int BYTE_W          = 8;
  localparam int CP_W            = 21;
  localparam int CNT_OUT_W       = 16;
  localparam int CAP_W           = 16;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 3;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  localparam logic [7:0] MASK_LEAD4 = 8'h07;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;
  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_CONT  = 8'h3F;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [2:0] KIND_ZERO   = 3'd0;
  localparam logic [2:0] KIND_LEAD2  = 3'd1;
  localparam logic [2:0] KIND_LEAD3  = 3'd2;
  localparam logic [2:0] KIND_LEAD4  = 3'd3;
  localparam logic [2:0] KIND_SINGLE = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic [BYTE_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic                 last;
    logic [CNT_OUT_W-1:0] char_count;
  } result_t;

endpackage

/* hw/rtl/utf8d_if.sv */
// stream interfaces of the utf8 decoder: byte input and code point output
// depends on utf8d_pkg
interface utf8d_byte_if;
  import utf8d_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8d_cp_if;
  import utf8d_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CP_W-1:0]      code_point;
  logic                 last;
  logic [CNT_OUT_W-1:0] char_count;
  modport source (output valid, output code_point, output last, output char_count,
                  input ready);
  modport sink   (input valid, input code_point, input last, input char_count,
                  output ready);
endinterface

/* hw/rtl/utf8_to_code_point_decoder_top.sv */
// utf8 decoder top level: configuration port, front stage, queue, back stage
// depends on utf8d_pkg, utf8d_if, utf8d_front, utf8d_queue, utf8d_back
//
// Takes one byte per clock while the output is not stalled and returns at most one
// result per byte, so results never outpace bytes; a byte's result passes the front
// register, a queue slot and the result register before it is on the output.
// The rate is set by the back stage, which does a byte's decode step and its
// character limit compare combinationally ahead of the result register. Capacity
// (offset 0) must only be written while no string is in flight.
module utf8_to_code_point_decoder_top #(
  parameter int COUNT_BITS  = utf8d_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  utf8d_byte_if.sink                   in_bytes,
  utf8d_cp_if.source                   out_chars,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [utf8d_pkg::ADDR_W-1:0] paddr,
  input  logic [utf8d_pkg::DATA_W-1:0] pwdata,
  output logic [utf8d_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import utf8d_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  entry_t           push_entry, pop_entry;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CAPACITY);
  assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_en) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  utf8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bytes   (in_bytes),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  utf8d_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (cap_r),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_chars (out_chars)
  );

endmodule

/* hw/rtl/utf8d_front.sv */
// front stage: accepts bytes, classifies them and registers them for the queue
// depends on utf8d_pkg, utf8d_if
module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  utf8d_byte_if.sink        in_bytes,
  output logic              push_valid,
  output utf8d_pkg::entry_t push_entry,
  input  logic              push_ready
);
  import utf8d_pkg::*;

  logic   vld_r, vld_nxt;
  entry_t ent_r;
  logic [2:0] kind;
  logic   take;

  always_comb begin
    logic [BYTE_W-1:0] b;
    b = in_bytes.data_byte;
    if (b == 8'h00) begin
      kind = KIND_ZERO;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      kind = KIND_LEAD2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      kind = KIND_LEAD3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      kind = KIND_LEAD4;
    end else begin
      kind = KIND_SINGLE;
    end
  end

  assign in_bytes.ready = !vld_r || push_ready;
  assign take           = in_bytes.valid && in_bytes.ready;
  assign vld_nxt        = take || (vld_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= '{kind: kind, data: in_bytes.data_byte};
    end
  end

  assign push_valid = vld_r;
  assign push_entry = ent_r;

endmodule

/* hw/rtl/utf8d_queue.sv */
// short queue between the front and back stages
// depends on utf8d_pkg
module utf8d_queue #(
  parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  utf8d_pkg::entry_t push_entry,
  output logic              push_ready,
  output logic              pop_valid,
  output utf8d_pkg::entry_t pop_entry,
  input  logic              pop_ready
);
  import utf8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               push, pop;

  assign push_ready = fill_r != CNT_W'(DEPTH);
  assign pop_valid  = fill_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

`include "utf8_to_code_point_decoder_top_assert.svh"

  `UTF8D_ASSERT_NEXT(a_fill_up, push && !pop, fill_r == $past(fill_r) + CNT_W'(1), "queue fill did not grow")
  `UTF8D_ASSERT_NEXT(a_fill_down, pop && !push, fill_r == $past(fill_r) - CNT_W'(1), "queue fill did not shrink")

endmodule

/* hw/rtl/utf8d_back.sv */
// back stage: sequence decoding, character limit and result register
// depends on utf8d_pkg, utf8d_if
module utf8d_back #(
  parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [utf8d_pkg::CAP_W-1:0] capacity,
  input  logic                        pop_valid,
  input  utf8d_pkg::entry_t           pop_entry,
  output logic                        pop_ready,
  utf8d_cp_if.source                  out_chars
);
  import utf8d_pkg::*;

  localparam int LW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

  logic [1:0]            pend_r, pend_nxt;
  logic [CP_W-1:0]       acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  disc_r, disc_nxt;
  logic                  out_vld_r;
  result_t               res_r, res_nxt;
  logic                  emit, take;
  logic [CAP_W-1:0]      cap_m1;
  logic [LW-1:0]         lim_w, cnt_max, cnt_w;

  assign pop_ready = !out_vld_r || out_chars.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    cap_m1  = (capacity == '0) ? '0 : capacity - CAP_W'(1);
    cnt_max = LW'({COUNT_BITS{1'b1}});
    lim_w   = LW'(cap_m1);
    if (lim_w > cnt_max) begin
      lim_w = cnt_max;
    end
    cnt_w = LW'(cnt_r);
  end

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    disc_nxt = disc_r;
    emit     = 1'b0;
    res_nxt  = '{code_point: '0, last: 1'b0, char_count: '0};
    if (pop_entry.kind == KIND_ZERO) begin
      emit     = 1'b1;
      res_nxt  = '{code_point: '0, last: 1'b1, char_count: cnt_w[CNT_OUT_W-1:0]};
      pend_nxt = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      disc_nxt = 1'b0;
    end else if (disc_r) begin
      emit = 1'b0;
    end else if (pend_r != 2'd0) begin
      acc_nxt  = {acc_r[CP_W-7:0], pop_entry.data[5:0] & MASK_CONT[5:0]};
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        emit               = 1'b1;
        res_nxt.code_point = acc_nxt;
        cnt_nxt            = cnt_r + COUNT_BITS'(1);
      end
    end else if (cnt_w >= lim_w) begin
      disc_nxt = 1'b1;
    end else begin
      case (pop_entry.kind)
        KIND_LEAD2: begin
          acc_nxt  = CP_W'(pop_entry.data & MASK_LEAD2);
          pend_nxt = 2'd1;
        end
        KIND_LEAD3: begin
          acc_nxt  = CP_W'(pop_entry.data & MASK_LEAD3);
          pend_nxt = 2'd2;
        end
        KIND_LEAD4: begin
          acc_nxt  = CP_W'(pop_entry.data & MASK_LEAD4);
          pend_nxt = 2'd3;
        end
        default: begin
          emit               = 1'b1;
          res_nxt.code_point = CP_W'(pop_entry.data);
          cnt_nxt            = cnt_r + COUNT_BITS'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      disc_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        pend_r <= pend_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        disc_r <= disc_nxt;
      end
      if (pop_ready) begin
        out_vld_r <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_chars.valid      = out_vld_r;
  assign out_chars.code_point = res_r.code_point;
  assign out_chars.last       = res_r.last;
  assign out_chars.char_count = res_r.char_count;

`include "utf8_to_code_point_decoder_top_assert.svh"

  `UTF8D_ASSERT_NOW(a_disc_idle, disc_r, pend_r == 2'd0, "discarding inside a sequence")
  `UTF8D_ASSERT_NEXT(a_term_clear, take && pop_entry.kind == KIND_ZERO, cnt_r == '0 && !disc_r && pend_r == 2'd0, "state not cleared after terminator")

endmodule
